// ===== src/text_console_cursor_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Text console cursor engine: assertion macros
// Shared concurrent-assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define TCCE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Types, codes and the microprogram of the text console cursor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;

    typedef logic [4:0]        row_port_t;
    typedef logic [6:0]        col_port_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;
    typedef logic [CELL_W-1:0] cell_t;
    // wide enough for any row or column limit in range
    typedef logic [8:0]        cmp_t;

    localparam char_t NEWLINE_CODE = 8'h0A;
    localparam char_t BLANK_CODE   = 8'h20;
    localparam attr_t RESET_ATTR   = 8'h02;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_IS_NL,
        COND_COL_FULL,
        COND_ROW_LAST,
        COND_BS_HOME,
        COND_SWEEP_MORE,
        COND_READ_OOR
    } cond_t;

    typedef enum logic [1:0] {
        ADDR_CURSOR,
        ADDR_READ,
        ADDR_SWEEP,
        ADDR_ROW_START
    } addr_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC_COL,
        CUR_NEXT_ROW,
        CUR_SCROLL,
        CUR_BACK,
        CUR_HOME
    } cursor_op_t;

    typedef enum logic [1:0] {
        SWP_HOLD,
        SWP_LOAD_ALL,
        SWP_LOAD_ROW,
        SWP_STEP
    } sweep_op_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    // microprogram addresses
    localparam upc_t S_IDLE         = 5'd0;
    localparam upc_t S_WR_CHECK     = 5'd1;
    localparam upc_t S_WR_FULL      = 5'd2;
    localparam upc_t S_PUT          = 5'd3;
    localparam upc_t S_NL           = 5'd4;
    localparam upc_t S_NEXT_ROW     = 5'd5;
    localparam upc_t S_SCROLL       = 5'd6;
    localparam upc_t S_SCROLL_BLANK = 5'd7;
    localparam upc_t S_NL_END       = 5'd8;
    localparam upc_t S_NL_RESUME    = 5'd9;
    localparam upc_t S_BS           = 5'd10;
    localparam upc_t S_BS_STEP      = 5'd11;
    localparam upc_t S_BS_BLANK     = 5'd12;
    localparam upc_t S_CLR          = 5'd13;
    localparam upc_t S_CLR_BLANK    = 5'd14;
    localparam upc_t S_EMIT         = 5'd15;
    localparam upc_t S_RD           = 5'd16;
    localparam upc_t S_RD_DATA      = 5'd17;
    localparam upc_t S_INIT         = 5'd18;
    localparam upc_t S_INIT_BLANK   = 5'd19;
    localparam upc_t S_INIT_END     = 5'd20;

    typedef struct packed {
        logic       dispatch;
        cond_t      cond;
        upc_t       target;
        logic       wr_en;
        addr_sel_t  addr_sel;
        logic       data_blank;
        logic       attr_init;
        cursor_op_t cursor_op;
        sweep_op_t  sweep_op;
        logic       emit;
        logic       capture;
    } ucw_t;

    typedef struct packed {
        logic       wr_en;
        addr_sel_t  addr_sel;
        logic       data_blank;
        logic       attr_init;
        cursor_op_t cursor_op;
        sweep_op_t  sweep_op;
    } dp_ctl_t;

    typedef struct packed {
        logic is_newline;
        logic col_full;
        logic row_last;
        logic bs_home;
        logic sweep_more;
        logic read_oor;
    } dp_status_t;

    // Control store. Fall-through goes to the next address.
    function automatic ucw_t ucode(upc_t a);
        ucw_t w;
        w = '{dispatch: 1'b0, cond: COND_NEVER, target: S_IDLE, wr_en: 1'b0,
              addr_sel: ADDR_CURSOR, data_blank: 1'b0, attr_init: 1'b0,
              cursor_op: CUR_HOLD, sweep_op: SWP_HOLD, emit: 1'b0, capture: 1'b0};
        unique case (a)
            S_IDLE:
            begin
                w.dispatch = 1'b1;
            end
            S_WR_CHECK:
            begin
                w.cond   = COND_IS_NL;
                w.target = S_NL;
            end
            S_WR_FULL:
            begin
                w.cond   = COND_COL_FULL;
                w.target = S_NL;
            end
            S_PUT:
            begin
                w.wr_en     = 1'b1;
                w.cursor_op = CUR_INC_COL;
                w.emit      = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = S_IDLE;
            end
            S_NL:
            begin
                w.cond   = COND_ROW_LAST;
                w.target = S_SCROLL;
            end
            S_NEXT_ROW:
            begin
                w.cursor_op = CUR_NEXT_ROW;
                w.cond      = COND_ALWAYS;
                w.target    = S_NL_END;
            end
            S_SCROLL:
            begin
                w.addr_sel  = ADDR_ROW_START;
                w.sweep_op  = SWP_LOAD_ROW;
                w.cursor_op = CUR_SCROLL;
            end
            S_SCROLL_BLANK:
            begin
                w.wr_en      = 1'b1;
                w.addr_sel   = ADDR_SWEEP;
                w.data_blank = 1'b1;
                w.sweep_op   = SWP_STEP;
                w.cond       = COND_SWEEP_MORE;
                w.target     = S_SCROLL_BLANK;
            end
            S_NL_END:
            begin
                w.cond   = COND_IS_NL;
                w.target = S_EMIT;
            end
            S_NL_RESUME:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_PUT;
            end
            S_BS:
            begin
                w.cond   = COND_BS_HOME;
                w.target = S_EMIT;
            end
            S_BS_STEP:
            begin
                w.cursor_op = CUR_BACK;
            end
            S_BS_BLANK:
            begin
                w.wr_en      = 1'b1;
                w.data_blank = 1'b1;
                w.emit       = 1'b1;
                w.cond       = COND_ALWAYS;
                w.target     = S_IDLE;
            end
            S_CLR:
            begin
                w.sweep_op  = SWP_LOAD_ALL;
                w.cursor_op = CUR_HOME;
            end
            S_CLR_BLANK:
            begin
                w.wr_en      = 1'b1;
                w.addr_sel   = ADDR_SWEEP;
                w.data_blank = 1'b1;
                w.sweep_op   = SWP_STEP;
                w.cond       = COND_SWEEP_MORE;
                w.target     = S_CLR_BLANK;
            end
            S_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_ALWAYS;
                w.target = S_IDLE;
            end
            S_RD:
            begin
                w.addr_sel = ADDR_READ;
                w.cond     = COND_READ_OOR;
                w.target   = S_EMIT;
            end
            S_RD_DATA:
            begin
                w.addr_sel = ADDR_READ;
                w.emit     = 1'b1;
                w.capture  = 1'b1;
                w.cond     = COND_ALWAYS;
                w.target   = S_IDLE;
            end
            S_INIT:
            begin
                w.sweep_op  = SWP_LOAD_ALL;
                w.cursor_op = CUR_HOME;
            end
            S_INIT_BLANK:
            begin
                w.wr_en      = 1'b1;
                w.addr_sel   = ADDR_SWEEP;
                w.data_blank = 1'b1;
                w.attr_init  = 1'b1;
                w.sweep_op   = SWP_STEP;
                w.cond       = COND_SWEEP_MORE;
                w.target     = S_INIT_BLANK;
            end
            S_INIT_END:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic upc_t op_entry(op_t o);
        upc_t e;
        unique case (o)
            OP_WRITE:     e = S_WR_CHECK;
            OP_BACKSPACE: e = S_BS;
            OP_CLEAR:     e = S_CLR;
            OP_READ:      e = S_RD;
            default:      e = S_IDLE;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

// ===== src/tcce_sequencer.sv =====
// ----------------------------------------------------------------------------
// tcce_sequencer
// Microprogram counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_sequencer
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    input  wire logic [tcce_pkg::OP_W-1:0] op,
    input  wire logic                     out_busy,
    input  wire tcce_pkg::dp_status_t     status,
    output logic                          in_ready,
    output tcce_pkg::dp_ctl_t             ctl,
    output logic                          emit,
    output logic                          capture
);

    tcce_pkg::upc_t upc_reg;
    tcce_pkg::upc_t upc_next;
    tcce_pkg::ucw_t word;
    logic           stall;
    logic           cond_hit;

    assign word  = tcce_pkg::ucode(upc_reg);
    // a result step waits while the output register is still full
    assign stall = word.emit && out_busy;

    always_comb
    begin
        unique case (word.cond)
            tcce_pkg::COND_NEVER:      cond_hit = 1'b0;
            tcce_pkg::COND_ALWAYS:     cond_hit = 1'b1;
            tcce_pkg::COND_IS_NL:      cond_hit = status.is_newline;
            tcce_pkg::COND_COL_FULL:   cond_hit = status.col_full;
            tcce_pkg::COND_ROW_LAST:   cond_hit = status.row_last;
            tcce_pkg::COND_BS_HOME:    cond_hit = status.bs_home;
            tcce_pkg::COND_SWEEP_MORE: cond_hit = status.sweep_more;
            tcce_pkg::COND_READ_OOR:   cond_hit = status.read_oor;
            default:                   cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        if (word.dispatch)
        begin
            if (in_valid)
            begin
                upc_next = tcce_pkg::op_entry(tcce_pkg::op_t'(op));
            end
        end
        else if (!stall)
        begin
            if (cond_hit)
            begin
                upc_next = word.target;
            end
            else
            begin
                upc_next = upc_reg + tcce_pkg::upc_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tcce_pkg::S_INIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign in_ready       = word.dispatch;
    assign emit           = word.emit && !stall;
    assign capture        = word.capture;
    assign ctl.wr_en      = word.wr_en && !stall;
    assign ctl.addr_sel   = word.addr_sel;
    assign ctl.data_blank = word.data_blank;
    assign ctl.attr_init  = word.attr_init;
    assign ctl.cursor_op  = stall ? tcce_pkg::CUR_HOLD : word.cursor_op;
    assign ctl.sweep_op   = stall ? tcce_pkg::SWP_HOLD : word.sweep_op;

endmodule

`default_nettype wire

// ===== src/tcce_datapath.sv =====
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor, scroll base, sweep counter, address generation and the cell store.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_datapath
#(
    parameter  int COLUMNS = 80,
    parameter  int ROWS    = 25,
    localparam int ROW_W   = $clog2(ROWS),
    localparam int COL_W   = $clog2(COLUMNS + 1),
    localparam int CELLS   = ROWS * COLUMNS,
    localparam int ADDR_W  = $clog2(CELLS)
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire tcce_pkg::char_t          char_code,
    input  wire tcce_pkg::row_port_t      read_row,
    input  wire tcce_pkg::col_port_t      read_column,
    input  wire tcce_pkg::attr_t          attr,
    input  wire tcce_pkg::dp_ctl_t        ctl,
    output tcce_pkg::dp_status_t          status,
    output logic [ROW_W-1:0]              row_next,
    output logic [COL_W-1:0]              col_next,
    output tcce_pkg::cell_t               rd_cell,
    output logic [ADDR_W-1:0]             cell_addr
);

    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [ROW_W:0]    ROWS_S     = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  COL_FULL_V = COL_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_SPAN   = ADDR_W'(COLUMNS - 1);
    localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);

    tcce_pkg::char_t     char_reg;
    tcce_pkg::row_port_t rd_row_reg;
    tcce_pkg::col_port_t rd_col_reg;

    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  base_reg;
    logic [ROW_W-1:0]  base_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] addr_next;
    logic [ADDR_W-1:0] last_reg;
    logic [ADDR_W-1:0] last_next;

    logic [ROW_W-1:0]  lrow;
    logic [COL_W-1:0]  lcol;
    logic [ROW_W:0]    row_sum;
    logic [ROW_W-1:0]  prow;
    logic [ADDR_W-1:0] lin;
    logic [ADDR_W-1:0] mem_addr;
    tcce_pkg::cell_t   wdata;
    tcce_pkg::cell_t   rd_cell_reg;

    tcce_pkg::cell_t   cell_mem [CELLS];

    // item payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg   <= char_code;
            rd_row_reg <= read_row;
            rd_col_reg <= read_column;
        end
    end

    // logical (row, column) of the access
    always_comb
    begin
        unique case (ctl.addr_sel)
            tcce_pkg::ADDR_CURSOR:
            begin
                lrow = row_reg;
                lcol = col_reg;
            end
            tcce_pkg::ADDR_READ:
            begin
                lrow = ROW_W'(rd_row_reg);
                lcol = COL_W'(rd_col_reg);
            end
            default:
            begin
                lrow = '0;
                lcol = '0;
            end
        endcase
    end

    // screen rows rotate over the store: physical row = (row + base) mod ROWS
    assign row_sum = {1'b0, lrow} + {1'b0, base_reg};
    always_comb
    begin
        if (ctl.addr_sel == tcce_pkg::ADDR_ROW_START)
        begin
            prow = base_reg;
        end
        else if (row_sum >= ROWS_S)
        begin
            prow = ROW_W'(row_sum - ROWS_S);
        end
        else
        begin
            prow = ROW_W'(row_sum);
        end
    end

    assign lin      = ADDR_W'(prow) * COLS_A + ADDR_W'(lcol);
    assign mem_addr = (ctl.addr_sel == tcce_pkg::ADDR_SWEEP) ? addr_reg : lin;
    assign wdata    = {(ctl.attr_init ? tcce_pkg::RESET_ATTR : attr),
                       (ctl.data_blank ? tcce_pkg::BLANK_CODE : char_reg)};

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            cell_mem[mem_addr] <= wdata;
        end
        rd_cell_reg <= cell_mem[mem_addr];
    end

    // cursor and scroll base
    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        base_next = base_reg;
        unique case (ctl.cursor_op)
            tcce_pkg::CUR_HOLD:
            begin
                col_next = col_reg;
            end
            tcce_pkg::CUR_INC_COL:
            begin
                col_next = col_reg + COL_W'(1);
            end
            tcce_pkg::CUR_NEXT_ROW:
            begin
                row_next = row_reg + ROW_W'(1);
                col_next = '0;
            end
            tcce_pkg::CUR_SCROLL:
            begin
                base_next = (base_reg == ROW_LAST) ? '0 : base_reg + ROW_W'(1);
                col_next  = '0;
            end
            tcce_pkg::CUR_BACK:
            begin
                if (col_reg != '0)
                begin
                    col_next = col_reg - COL_W'(1);
                end
                else
                begin
                    row_next = row_reg - ROW_W'(1);
                    col_next = COL_LAST;
                end
            end
            tcce_pkg::CUR_HOME:
            begin
                row_next  = '0;
                col_next  = '0;
                base_next = '0;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase
    end

    // sweep address for init, clear and scroll blanking
    always_comb
    begin
        addr_next = addr_reg;
        last_next = last_reg;
        unique case (ctl.sweep_op)
            tcce_pkg::SWP_HOLD:
            begin
                addr_next = addr_reg;
            end
            tcce_pkg::SWP_LOAD_ALL:
            begin
                addr_next = '0;
                last_next = LAST_CELL;
            end
            tcce_pkg::SWP_LOAD_ROW:
            begin
                addr_next = lin;
                last_next = lin + ROW_SPAN;
            end
            tcce_pkg::SWP_STEP:
            begin
                addr_next = addr_reg + ADDR_W'(1);
            end
            default:
            begin
                addr_next = addr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            base_reg <= '0;
            addr_reg <= '0;
            last_reg <= '0;
        end
        else
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            base_reg <= base_next;
            addr_reg <= addr_next;
            last_reg <= last_next;
        end
    end

    assign status.is_newline = (char_reg == tcce_pkg::NEWLINE_CODE);
    assign status.col_full   = (col_reg == COL_FULL_V);
    assign status.row_last   = (row_reg == ROW_LAST);
    assign status.bs_home    = (row_reg == '0) && (col_reg == '0);
    assign status.sweep_more = (addr_reg != last_reg);
    assign status.read_oor   = (tcce_pkg::cmp_t'(rd_row_reg) >= tcce_pkg::cmp_t'(ROWS)) ||
                               (tcce_pkg::cmp_t'(rd_col_reg) >= tcce_pkg::cmp_t'(COLUMNS));

    assign rd_cell   = rd_cell_reg;
    assign cell_addr = mem_addr;

endmodule

`default_nettype wire

// ===== src/text_console_cursor_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine
// One item at a time: a new item is accepted only once the previous one has
// finished and the sequencer is back in idle. On the last row, newline and wrap
// also run a one-row scroll sweep; clear sweeps the whole store. A full output
// register stalls the result step. After reset a clearing pass blanks the store
// with attribute 0x02 before the first item; config is always taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_cursor_engine_defines.svh"

module text_console_cursor_engine
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    // configuration: text attribute register
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire tcce_pkg::attr_t     cfg_data,

    // item input
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          op,
    input  wire tcce_pkg::char_t     char_code,
    input  wire tcce_pkg::row_port_t read_row,
    input  wire tcce_pkg::col_port_t read_column,

    // result output
    output logic                     out_valid,
    input  wire logic                out_ready,
    output tcce_pkg::row_port_t      cursor_row,
    output tcce_pkg::col_port_t      cursor_column,
    output tcce_pkg::char_t          cell_character,
    output tcce_pkg::attr_t          cell_attribute
);

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    // Structure:
    //   sequencer - microprogram counter over a small control store; each
    //               step issues one control word and an optional jump.
    //   datapath  - cursor, rotating row base (scroll is a base bump plus a
    //               one-row blanking sweep), sweep counter, cell store.
    // The output register decouples result delivery; a result step only
    // stalls when that register is still holding an untaken item.

    tcce_pkg::attr_t      attr_reg;
    logic                 out_valid_reg;
    tcce_pkg::row_port_t  cursor_row_reg;
    tcce_pkg::col_port_t  cursor_column_reg;
    tcce_pkg::char_t      cell_character_reg;
    tcce_pkg::attr_t      cell_attribute_reg;

    tcce_pkg::dp_ctl_t    ctl;
    tcce_pkg::dp_status_t status;
    logic                 emit;
    logic                 capture;
    logic                 out_busy;
    logic                 accept;
    logic [ROW_W-1:0]     row_next;
    logic [COL_W-1:0]     col_next;
    tcce_pkg::cell_t      rd_cell;
    logic [ADDR_W-1:0]    cell_addr;

    assign accept    = in_valid && in_ready;
    assign out_busy  = out_valid_reg && !out_ready;
    assign cfg_ready = 1'b1;

    tcce_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .out_busy (out_busy),
        .status   (status),
        .in_ready (in_ready),
        .ctl      (ctl),
        .emit     (emit),
        .capture  (capture)
    );

    tcce_datapath
    #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .char_code   (char_code),
        .read_row    (read_row),
        .read_column (read_column),
        .attr        (attr_reg),
        .ctl         (ctl),
        .status      (status),
        .row_next    (row_next),
        .col_next    (col_next),
        .rd_cell     (rd_cell),
        .cell_addr   (cell_addr)
    );

    // attribute register; only affects cells written afterwards
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= tcce_pkg::RESET_ATTR;
        end
        else if (cfg_valid)
        begin
            attr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result carries the cursor as it stands after the step's own update
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cursor_row_reg     <= tcce_pkg::row_port_t'(row_next);
            cursor_column_reg  <= tcce_pkg::col_port_t'(col_next);
            cell_character_reg <= capture ? rd_cell[tcce_pkg::CHAR_W-1:0] : '0;
            cell_attribute_reg <= capture ? rd_cell[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W] : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cursor_row     = cursor_row_reg;
    assign cursor_column  = cursor_column_reg;
    assign cell_character = cell_character_reg;
    assign cell_attribute = cell_attribute_reg;

    `TCCE_ASSERT_NEXT(a_accept_leaves_idle, accept, !in_ready, "item accepted but sequencer stayed idle")
    `TCCE_ASSERT_IMP(a_write_in_store, ctl.wr_en, int'(cell_addr) < ROWS * COLUMNS, "cell write outside store")
    `TCCE_ASSERT_IMP(a_cursor_bounds, 1'b1, (int'(row_next) < ROWS) && (int'(col_next) <= COLUMNS), "cursor out of range")

endmodule

`default_nettype wire
